// File: rtl/tst_pkg.sv
`timescale 1ns / 1ps
// tst_pkg: shared types and constants of the tunnel session table
// used by tst_cell and tunnel_session_table, depends on nothing
package tst_pkg;

   localparam logic [1:0] OP_ESTABLISH = 2'd0;
   localparam logic [1:0] OP_UPLINK    = 2'd1;
   localparam logic [1:0] OP_DOWNLINK  = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   localparam logic [31:0] FIRST_TUNNEL_ID = 32'd20000;

   // request keys, broadcast to every cell while a scan runs
   typedef struct packed {
      logic [1:0]  opcode;
      logic [49:0] subscriber;
      logic [7:0]  session;
      logic [31:0] address;
      logic [31:0] tunnel;
   } req_key_type;

   // one stored session context, also the write bus payload
   typedef struct packed {
      logic [49:0] subscriber;
      logic [7:0]  session;
      logic [31:0] address;
      logic [31:0] peer_id;
      logic [31:0] local_id;
   } entry_type;

   // running scan result handed from cell to cell
   typedef struct packed {
      logic        hit;
      logic        has_free;
      logic [49:0] subscriber;
      logic [7:0]  session;
      logic [31:0] local_id;
      logic [31:0] peer_id;
   } scan_type;

endpackage

// File: rtl/tunnel_session_table.sv
`timescale 1ns / 1ps
// tunnel_session_table: session table of tunnel contexts, top level
// depends on tst_pkg and tst_cell
//
// usage
//  - req_ channel carries one request item: establish, uplink lookup by
//    local tunnel id, or downlink lookup by UE address
//  - rsp_ channel returns exactly one result item per request
//  - each table slot lives in its own cell; a scan token walks the row of
//    cells one cell per cycle, carrying the first match and first free slot
//  - the time from accept to rsp_valid is set by the token walk through
//    the row of cells; one item is in flight at a time, so a new item
//    is accepted only once the last result goes to the output register
//  - req_stall is high while an item is being scanned or its result waits
//    to be written into the output register
//  - the output register holds the last result; a new item may be accepted
//    while it still waits, and the next result waits in turn until rsp_stall
//    drops before the table is updated
//  - reset clears all slot valid bits, the response valid, and loads the
//    tunnel id counter with 20000; slot contents need no clearing
module tunnel_session_table
   import tst_pkg::*;
#(
   parameter int SESSIONS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [49:0] req_subscriber_id,
   input  logic [7:0]  req_session_number,
   input  logic [31:0] req_ue_address,
   input  logic [31:0] req_peer_tunnel_id,
   input  logic [31:0] req_lookup_tunnel_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_local_tunnel_id,
   output logic [31:0] rsp_remote_tunnel_id,
   output logic [49:0] rsp_echo_subscriber,
   output logic [7:0]  rsp_echo_session
);

   localparam int SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic        launch_ff, launch_in;
   logic [31:0] next_id_ff, next_id_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_local_ff, rsp_local_in;
   logic [31:0] rsp_remote_ff, rsp_remote_in;
   logic [49:0] rsp_sub_ff, rsp_sub_in;
   logic [7:0]  rsp_ses_ff, rsp_ses_in;

   req_key_type key_ff;
   logic [31:0] peer_ff;

   logic        accept;
   logic        emit;
   logic [31:0] assign_id;

   // write bus into the cells
   logic              wr_en;
   logic [SLOT_W-1:0] wr_slot;
   entry_type         wr_data;

   // links between neighboring cells, link 0 is the head of the row
   logic              link_tok      [SESSIONS+1];
   scan_type          link_carry    [SESSIONS+1];
   logic [SLOT_W-1:0] link_hit_idx  [SESSIONS+1];
   logic [SLOT_W-1:0] link_free_idx [SESSIONS+1];

   scan_type scan_done;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // token enters the head with an empty scan result
   assign link_tok[0]      = launch_ff;
   assign link_carry[0]    = '0;
   assign link_hit_idx[0]  = '0;
   assign link_free_idx[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < SESSIONS; gi++) begin : g_cell
         tst_cell #(
            .SLOT_W (SLOT_W),
            .SLOT   (gi)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .key_i        (key_ff),
            .tok_in       (link_tok[gi]),
            .carry_in     (link_carry[gi]),
            .hit_idx_in   (link_hit_idx[gi]),
            .free_idx_in  (link_free_idx[gi]),
            .wr_en        (wr_en),
            .wr_slot      (wr_slot),
            .wr_data      (wr_data),
            .tok_out      (link_tok[gi+1]),
            .carry_out    (link_carry[gi+1]),
            .hit_idx_out  (link_hit_idx[gi+1]),
            .free_idx_out (link_free_idx[gi+1])
         );
      end
   endgenerate

   // tail of the row holds its result until the next scan
   assign scan_done = link_carry[SESSIONS];

   // counter restarts at 20000 when it has wrapped to zero
   assign assign_id = (next_id_ff == 32'd0) ? FIRST_TUNNEL_ID : next_id_ff;

   assign emit = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      launch_in     = 1'b0;
      next_id_in    = next_id_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_local_in  = rsp_local_ff;
      rsp_remote_in = rsp_remote_ff;
      rsp_sub_in    = rsp_sub_ff;
      rsp_ses_in    = rsp_ses_ff;
      wr_en         = 1'b0;
      wr_slot       = link_hit_idx[SESSIONS];
      wr_data.subscriber = key_ff.subscriber;
      wr_data.session    = key_ff.session;
      wr_data.address    = key_ff.address;
      wr_data.peer_id    = peer_ff;
      wr_data.local_id   = assign_id;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_SCAN;
               launch_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (link_tok[SESSIONS]) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (emit) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_MISS;
               rsp_local_in  = '0;
               rsp_remote_in = '0;
               rsp_sub_in    = '0;
               rsp_ses_in    = '0;
               case (key_ff.opcode)
                  OP_ESTABLISH: begin
                     rsp_sub_in = key_ff.subscriber;
                     rsp_ses_in = key_ff.session;
                     if (scan_done.hit || scan_done.has_free) begin
                        // existing entry is overwritten, else lowest free slot
                        wr_en         = 1'b1;
                        wr_slot       = scan_done.hit ? link_hit_idx[SESSIONS]
                                                      : link_free_idx[SESSIONS];
                        next_id_in    = assign_id + 32'd1;
                        rsp_status_in = STATUS_OK;
                        rsp_local_in  = assign_id;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_UPLINK: begin
                     if (scan_done.hit) begin
                        rsp_status_in = STATUS_OK;
                        rsp_local_in  = scan_done.local_id;
                        rsp_sub_in    = scan_done.subscriber;
                        rsp_ses_in    = scan_done.session;
                     end
                  end
                  OP_DOWNLINK: begin
                     if (scan_done.hit) begin
                        rsp_status_in = STATUS_OK;
                        rsp_local_in  = scan_done.local_id;
                        rsp_remote_in = scan_done.peer_id;
                        rsp_sub_in    = scan_done.subscriber;
                        rsp_ses_in    = scan_done.session;
                     end
                  end
                  default: begin
                     // unused opcode answers as a miss
                     rsp_status_in = STATUS_MISS;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         next_id_ff   <= FIRST_TUNNEL_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_local_ff  <= rsp_local_in;
      rsp_remote_ff <= rsp_remote_in;
      rsp_sub_ff    <= rsp_sub_in;
      rsp_ses_ff    <= rsp_ses_in;
   end

   // request held for the whole scan
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff.opcode     <= req_opcode;
         key_ff.subscriber <= req_subscriber_id;
         key_ff.session    <= req_session_number;
         key_ff.address    <= req_ue_address;
         key_ff.tunnel     <= req_lookup_tunnel_id;
         peer_ff           <= req_peer_tunnel_id;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_local_tunnel_id  = rsp_local_ff;
   assign rsp_remote_tunnel_id = rsp_remote_ff;
   assign rsp_echo_subscriber  = rsp_sub_ff;
   assign rsp_echo_session     = rsp_ses_ff;

endmodule

// File: rtl/tst_cell.sv
`timescale 1ns / 1ps
// tst_cell: one slot of the session table plus one stage of the scan chain
// depends on tst_pkg
module tst_cell
   import tst_pkg::*;
#(
   parameter int SLOT_W = 6,
   parameter int SLOT   = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  req_key_type       key_i,
   input  logic              tok_in,
   input  scan_type          carry_in,
   input  logic [SLOT_W-1:0] hit_idx_in,
   input  logic [SLOT_W-1:0] free_idx_in,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  entry_type         wr_data,
   output logic              tok_out,
   output scan_type          carry_out,
   output logic [SLOT_W-1:0] hit_idx_out,
   output logic [SLOT_W-1:0] free_idx_out
);

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

   logic              valid_ff;
   entry_type         entry_ff;
   logic              tok_ff;
   scan_type          carry_ff;
   scan_type          carry_in_next;
   logic [SLOT_W-1:0] hit_idx_ff;
   logic [SLOT_W-1:0] hit_idx_in_next;
   logic [SLOT_W-1:0] free_idx_ff;
   logic [SLOT_W-1:0] free_idx_in_next;
   logic              match;

   always_comb begin
      case (key_i.opcode)
         OP_ESTABLISH: match = (entry_ff.subscriber == key_i.subscriber) &&
                               (entry_ff.session == key_i.session);
         OP_UPLINK:    match = (entry_ff.local_id == key_i.tunnel);
         OP_DOWNLINK:  match = (entry_ff.address == key_i.address);
         default:      match = 1'b0;
      endcase
      match = match && valid_ff;
   end

   // first match and first free slot win, later cells pass them on
   always_comb begin
      carry_in_next    = carry_in;
      hit_idx_in_next  = hit_idx_in;
      free_idx_in_next = free_idx_in;
      if (!carry_in.hit && match) begin
         carry_in_next.hit        = 1'b1;
         carry_in_next.subscriber = entry_ff.subscriber;
         carry_in_next.session    = entry_ff.session;
         carry_in_next.local_id   = entry_ff.local_id;
         carry_in_next.peer_id    = entry_ff.peer_id;
         hit_idx_in_next          = MY_SLOT;
      end
      if (!carry_in.has_free && !valid_ff) begin
         carry_in_next.has_free = 1'b1;
         free_idx_in_next       = MY_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (wr_en && (wr_slot == MY_SLOT)) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_slot == MY_SLOT)) begin
         entry_ff <= wr_data;
      end
      if (tok_in) begin
         carry_ff    <= carry_in_next;
         hit_idx_ff  <= hit_idx_in_next;
         free_idx_ff <= free_idx_in_next;
      end
   end

   assign tok_out      = tok_ff;
   assign carry_out    = carry_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule
